@@ rtl/core/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants of the Huffman symbol encoder.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int SymbolCountDef = 256;
  localparam int MaxCodeBitsDef = 16;
  localparam int FieldCodeBits  = 16;
  localparam int LenW           = 5;
  localparam int ByteBits       = 8;
  localparam int QueueDepth     = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [15:0] code_bits;
    logic [4:0]  code_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last;
  } out_item_t;

  // command handed from the lookup stage to the packer
  typedef struct packed {
    logic valid;
    logic flush;
  } pack_cmd_t;

  // bytes produced by the packer in one cycle
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } pack_res_t;

endpackage

@@ rtl/core/hse_ram.sv @@
// ----------------------------------------------------------------------------
// hse_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hse_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  logic [Width-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic [Width-1:0]                       rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/hse_packer.sv @@
// ----------------------------------------------------------------------------
// hse_packer
// Bit accumulator: appends a code word to the pending bits and splits off
// the completed bytes, or flushes the partial byte.
// ----------------------------------------------------------------------------
module hse_packer #(
  parameter int CodeW = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hse_pkg::pack_cmd_t        cmd,
  input  logic [CodeW-1:0]          code,
  input  logic [hse_pkg::LenW-1:0]  len,
  output hse_pkg::pack_res_t        res
);
  import hse_pkg::*;

  // pending bits kept left-aligned, unused low bits zero
  logic [6:0]  pend_r, pend_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] code16;
  logic [15:0] code_left;
  logic [23:0] code_ext;
  logic [23:0] win;
  logic [4:0]  total;
  logic [7:0]  rem;

  always_comb begin
    code16    = FieldCodeBits'(code);
    code_left = code16 << (LenW'(FieldCodeBits) - len);
    code_ext  = {code_left, 8'b0} >> cnt_r;
    win       = {pend_r, 17'b0} | code_ext;
    total     = {2'b0, cnt_r} + len;

    if (total[4]) begin
      rem = win[7:0];
    end else if (total[3]) begin
      rem = win[15:8];
    end else begin
      rem = win[23:16];
    end

    res            = '0;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    if (cmd.valid) begin
      if (cmd.flush) begin
        res.count          = (cnt_r != 3'd0) ? 2'd1 : 2'd0;
        res.first.byte_out = {pend_r, 1'b0};
        res.first.last     = 1'b1;
        pend_nxt           = '0;
        cnt_nxt            = '0;
      end else begin
        res.count           = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
        res.first.byte_out  = win[23:16];
        res.first.last      = ~total[4];
        res.second.byte_out = win[15:8];
        res.second.last     = 1'b1;
        pend_nxt            = rem[7:1];
        cnt_nxt             = total[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0) |-> (pend_r == 7'd0))
    else $error("pending bits set with empty accumulator");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.valid && cmd.flush) |=> (cnt_r == 3'd0))
    else $error("accumulator not empty after flush");
`endif

endmodule

@@ rtl/core/hse_out_queue.sv @@
// ----------------------------------------------------------------------------
// hse_out_queue
// Small result queue: takes up to two bytes a cycle, hands out one while not stalled.
// ----------------------------------------------------------------------------
module hse_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hse_pkg::pack_res_t   res,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hse_pkg::out_item_t   out_data
);
  import hse_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  out_item_t         ent_r [QueueDepth];
  logic [PtrW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rp_r];
  assign room      = (cnt_r <= CntW'(QueueDepth - 2));

  always_comb begin
    wp_nxt  = wp_r + PtrW'(res.count);
    rp_nxt  = rp_r + PtrW'(pop);
    cnt_nxt = cnt_r + CntW'(res.count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) begin
      ent_r[wp_r] <= res.first;
    end
    if (res.count == 2'd2) begin
      ent_r[wp_r + PtrW'(1)] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QueueDepth))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (res.count != 2'd0) |-> room)
    else $error("bytes pushed without room");
`endif

endmodule

@@ rtl/core/huffman_symbol_encoder.sv @@
// ----------------------------------------------------------------------------
// huffman_symbol_encoder
// Per-symbol Huffman encoder with loadable code table and byte packer.
// ----------------------------------------------------------------------------
// A load transaction writes one table entry; an encode transaction reads the
// code of its symbol from the table RAM (registered read) in the cycle after
// acceptance, and once the result queue has room for two bytes the packer
// pushes the completed bytes into that four-entry queue, which registers them
// before they are offered. A new transaction is taken every cycle while the
// queue has room for two bytes. The result channel moves one byte per cycle
// while out_stall is low, so sustained rate is one item per cycle for items
// that give at most one byte; two-byte encodes are held back as the queue fills.
// ----------------------------------------------------------------------------
module huffman_symbol_encoder #(
  parameter int SYMBOL_COUNT  = hse_pkg::SymbolCountDef,
  parameter int MAX_CODE_BITS = hse_pkg::MaxCodeBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hse_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hse_pkg::out_item_t  out_data
);
  import hse_pkg::*;

  localparam int AddrW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CodeW = (MAX_CODE_BITS < FieldCodeBits) ? MAX_CODE_BITS : FieldCodeBits;
  localparam int RamW  = CodeW + LenW;

  logic             in_acc;
  logic             sym_ok;
  logic [LenW-1:0]  len_clamp;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] addr;
  logic [RamW-1:0]  wr_data, rd_data;
  pack_cmd_t        cmd_r, cmd_nxt, pack_cmd;
  pack_res_t        res;
  logic             room;
  logic             fire;

  assign in_acc = in_valid && !in_stall;
  assign sym_ok = ({24'b0, in_data.symbol} < 32'(SYMBOL_COUNT));
  assign addr   = AddrW'(in_data.symbol);

  // lengths beyond the code width are stored clamped
  assign len_clamp = (32'(in_data.code_len) > CodeW) ? LenW'(CodeW) : in_data.code_len;

  assign wr_en   = in_acc && (in_data.opcode == OP_LOAD) && sym_ok;
  assign wr_data = {len_clamp, in_data.code_bits[CodeW-1:0]};
  assign rd_en   = in_acc && (in_data.opcode == OP_ENCODE);

  hse_ram #(
    .Width (RamW),
    .Depth (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign fire     = cmd_r.valid && room;
  assign in_stall = cmd_r.valid && !room;

  always_comb begin
    cmd_nxt = cmd_r;
    if (in_acc) begin
      cmd_nxt.valid = ((in_data.opcode == OP_ENCODE) && sym_ok) ||
                      (in_data.opcode == OP_FLUSH);
      cmd_nxt.flush = (in_data.opcode == OP_FLUSH);
    end else if (fire) begin
      cmd_nxt.valid = 1'b0;
    end
    pack_cmd       = cmd_r;
    pack_cmd.valid = fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= '0;
    end else begin
      cmd_r <= cmd_nxt;
    end
  end

  hse_packer #(
    .CodeW (CodeW)
  ) u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pack_cmd),
    .code  (rd_data[CodeW-1:0]),
    .len   (rd_data[RamW-1 -: LenW]),
    .res   (res)
  );

  hse_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_stall_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r.valid && !room) |=> cmd_r.valid)
    else $error("lookup stage dropped a waiting transaction");
`endif

endmodule
